// ----- rtl/text_console_writer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// text_console_writer_unit_macros.svh
// Assertion shorthands shared by the console writer modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// condition holds at every edge outside reset
`define TCW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TCW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int CODE_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int CELL_W     = 16;
   localparam int POS_W      = 11;
   localparam int ADDR_IN_W  = 11;
   localparam int OP_W       = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CODE_W-1:0]  BLANK_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;
   localparam logic [CELL_W-1:0]  RESET_BLANK  = {COLOR_RESET, BLANK_CODE};

   // word index of the one register (paddr bit 2)
   localparam logic REG_TEXT_COLOR = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_BACK  = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CUR_HOLD    = 3'd0,
      CUR_NEWLINE = 3'd1,
      CUR_ADVANCE = 3'd2,
      CUR_BACK    = 3'd3,
      CUR_HOME    = 3'd4
   } cur_cmd_type;

   typedef struct packed {
      logic at_origin;
      logic at_last_row;
      logic at_line_end;
      logic at_col0;
   } cur_stat_type;

endpackage

// ----- rtl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor row, column and row base; moves on one command per cycle.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_macros.svh"

module tcw_cursor
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cur_cmd_type                        cmd,
   output logic [$clog2(COLUMNS*ROWS)-1:0]    pos,
   output cur_stat_type                       stat
);

   localparam int AW = $clog2(COLUMNS*ROWS);
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS-1);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS-1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
   localparam logic [AW-1:0] LAST_BASE = AW'((ROWS-1)*COLUMNS);

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] base_ff, base_in;   // row_ff * COLUMNS

   assign stat.at_col0     = (col_ff == '0);
   assign stat.at_line_end = (col_ff == LAST_COL);
   assign stat.at_last_row = (row_ff == LAST_ROW);
   assign stat.at_origin   = (col_ff == '0) && (row_ff == '0);

   assign pos = base_ff + AW'(col_ff);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      base_in = base_ff;
      unique case (cmd)
         CUR_HOLD: begin
         end
         CUR_NEWLINE, CUR_ADVANCE: begin
            if (cmd == CUR_ADVANCE && col_ff != LAST_COL) begin
               col_in = col_ff + 1'b1;
            end else begin
               col_in = '0;
               // past the last row the screen scrolls; cursor keeps the row
               if (row_ff != LAST_ROW) begin
                  row_in  = row_ff + 1'b1;
                  base_in = base_ff + ROW_STEP;
               end
            end
         end
         CUR_BACK: begin
            if (col_ff != '0) begin
               col_in = col_ff - 1'b1;
            end else if (row_ff != '0) begin
               row_in  = row_ff - 1'b1;
               col_in  = LAST_COL;
               base_in = base_ff - ROW_STEP;
            end
         end
         CUR_HOME: begin
            row_in  = '0;
            col_in  = '0;
            base_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         base_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         base_ff <= base_in;
      end
   end

   `TCW_ASSERT_ALWAYS(a_row_in_range, clock, reset, {1'b0, row_ff} < (RW+1)'(ROWS), "row out of range")
   `TCW_ASSERT_ALWAYS(a_col_in_range, clock, reset, {1'b0, col_ff} < (CW+1)'(COLUMNS), "column out of range")
   `TCW_ASSERT_IMPLY(a_base_tracks_row, clock, reset, stat.at_last_row, base_ff == LAST_BASE, "row base lost")

endmodule

// ----- rtl/text_console_writer_unit.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell console: screen RAM, cursor, scroll and clear sequencer.
// ----------------------------------------------------------------------------
//
//   port group   role      handshake              payload
//   req_*        input     req_valid / req_stall  op, char_code, cell_address
//   rsp_*        result    rsp_valid / rsp_stall  cursor_position, cell_data,
//                                                 scrolled
//   csr_*        config    APB-style write/read   text_color at byte 0
//
// Sequence: put character and backspace go from idle to the done state, read
// cell waits in the read state for the registered RAM data first. Clear and a put
// that scrolls pass through the fill (and for a scroll the row copy) states: both
// are bound by the single write port of the screen RAM, one cell per cycle.
// Reset: synchronous; afterwards a clearing pass writes the reset blank into
// every cell with req_stall high. CSR writes are taken during the pass.
// Stalls: a finished result is parked in the output register while the next
// item is accepted and worked on; that item waits for the register to drain.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_macros.svh"

module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_op,
   input  logic [CODE_W-1:0]     req_char_code,
   input  logic [ADDR_IN_W-1:0]  req_cell_address,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_W-1:0]      rsp_cursor_position,
   output logic [CELL_W-1:0]     rsp_cell_data,
   output logic                  rsp_scrolled,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT-1);
   localparam logic [AW-1:0] FIRST_SRC = AW'(COLUMNS);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,   // reset clearing pass
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,   // waiting on RAM read data
      ST_SCROLL = 6'b001000,   // row copy, one cell per cycle
      ST_FILL   = 6'b010000,   // blank fill up to the last cell
      ST_DONE   = 6'b100000    // result waiting for the output register
   } state_type;

   state_type state_ff, state_in;

   // ---------------------------------------------------------------- CSR ---
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_TEXT_COLOR);
   assign color_in   = csr_wr ? csr_pwdata[COLOR_W-1:0] : color_ff;
   assign csr_prdata = (csr_paddr[2] == REG_TEXT_COLOR) ?
                       CSR_DATA_W'(color_ff) : '0;

   // ------------------------------------------------------------- cursor ---
   cur_cmd_type    cur_cmd;
   cur_stat_type   cur_stat;
   logic [AW-1:0]  cur_pos;

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock (clock),
      .reset (reset),
      .cmd   (cur_cmd),
      .pos   (cur_pos),
      .stat  (cur_stat)
   );

   // ---------------------------------------------------------- screen RAM ---
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ----------------------------------------------------------- sequencer ---
   logic [AW-1:0]     cnt_ff, cnt_in;          // write pointer of sweeps
   logic [AW-1:0]     src_ff, src_in;          // read pointer of the row copy
   logic              rd_more_ff, rd_more_in;  // copy reads still to issue
   logic              copy_ff, copy_in;        // copy write due this cycle
   logic [CELL_W-1:0] fill_ff, fill_in;        // blank used by the fill
   logic              in_range_ff, in_range_in;
   logic [CELL_W-1:0] res_data_ff, res_data_in;
   logic              res_scrolled_ff, res_scrolled_in;

   logic              accept;
   logic              out_free;
   logic              put_scroll;
   logic [CELL_W-1:0] blank_now;
   op_type            op;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_scr_ff, rsp_scr_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign op        = op_type'(req_op);
   assign blank_now = {color_ff, BLANK_CODE};
   // a newline or a wrap out of the last row shifts the screen up
   assign put_scroll = ((req_char_code == NEWLINE_CODE) || cur_stat.at_line_end) &&
                       cur_stat.at_last_row;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      src_in          = src_ff;
      rd_more_in      = rd_more_ff;
      copy_in         = 1'b0;
      fill_in         = fill_ff;
      in_range_in     = in_range_ff;
      res_data_in     = res_data_ff;
      res_scrolled_in = res_scrolled_ff;
      cur_cmd         = CUR_HOLD;
      ram_we          = 1'b0;
      ram_waddr       = cnt_ff;
      ram_wdata       = fill_ff;
      ram_re          = 1'b0;
      ram_raddr       = src_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_pos_in      = rsp_pos_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_scr_in      = rsp_scr_ff;

      unique case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_BLANK;
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               res_data_in     = '0;
               res_scrolled_in = 1'b0;
               state_in        = ST_DONE;
               unique case (op)
                  OP_PUT: begin
                     if (req_char_code == NEWLINE_CODE) begin
                        cur_cmd = CUR_NEWLINE;
                     end else begin
                        cur_cmd   = CUR_ADVANCE;
                        ram_we    = 1'b1;
                        ram_waddr = cur_pos;
                        ram_wdata = {color_ff, req_char_code};
                     end
                     if (put_scroll) begin
                        res_scrolled_in = 1'b1;
                        state_in        = ST_SCROLL;
                        cnt_in          = '0;
                        src_in          = FIRST_SRC;
                        rd_more_in      = 1'b1;
                        fill_in         = blank_now;
                     end
                  end
                  OP_BACK: begin
                     cur_cmd = CUR_BACK;
                     if (!cur_stat.at_origin) begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_pos - 1'b1;
                        ram_wdata = blank_now;
                     end
                  end
                  OP_READ: begin
                     ram_re      = 1'b1;
                     ram_raddr   = AW'(req_cell_address);
                     in_range_in = (32'(req_cell_address) < 32'(CELL_COUNT));
                     state_in    = ST_READ;
                  end
                  OP_CLEAR: begin
                     cur_cmd  = CUR_HOME;
                     cnt_in   = '0;
                     fill_in  = blank_now;
                     state_in = ST_FILL;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_READ: begin
            res_data_in = in_range_ff ? ram_rdata : '0;
            state_in    = ST_DONE;
         end

         ST_SCROLL: begin
            // read runs one cell ahead of the write, COLUMNS cells above it
            if (rd_more_ff) begin
               ram_re     = 1'b1;
               ram_raddr  = src_ff;
               src_in     = src_ff + 1'b1;
               rd_more_in = (src_ff != LAST_CELL);
            end
            copy_in = rd_more_ff;
            if (copy_ff) begin
               ram_we    = 1'b1;
               ram_waddr = cnt_ff;
               ram_wdata = ram_rdata;
               cnt_in    = cnt_ff + 1'b1;
               if (!rd_more_ff) begin
                  state_in = ST_FILL;   // bottom row left to blank
               end
            end
         end

         ST_FILL: begin
            ram_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(cur_pos);
               rsp_data_in  = res_data_ff;
               rsp_scr_in   = res_scrolled_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         rd_more_ff   <= 1'b0;
         copy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= COLOR_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_more_ff   <= rd_more_in;
         copy_ff      <= copy_in;
         rsp_valid_ff <= rsp_valid_in;
         color_ff     <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff          <= src_in;
      fill_ff         <= fill_in;
      in_range_ff     <= in_range_in;
      res_data_ff     <= res_data_in;
      res_scrolled_ff <= res_scrolled_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_scr_ff      <= rsp_scr_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_data       = rsp_data_ff;
   assign rsp_scrolled        = rsp_scr_ff;

   `TCW_ASSERT_IMPLY(a_scroll_lands_last_row, clock, reset, (state_ff == ST_DONE) && res_scrolled_ff, cur_stat.at_last_row && cur_stat.at_col0, "scroll left cursor off the last row start")
   `TCW_ASSERT_IMPLY(a_copy_below_source, clock, reset, (state_ff == ST_SCROLL) && copy_ff && rd_more_ff, cnt_ff < src_ff, "row copy write overtook its read")
   `TCW_ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE), "result loaded outside done state")

endmodule

// ----- verif/screen_mirror_pkg.sv -----
// ----------------------------------------------------------------------------
// screen_mirror_pkg
// Shadow copy of the console screen, cursor and color; queues the cursor
// reports each accepted item must produce and checks the ones that arrive.
// ----------------------------------------------------------------------------
package screen_mirror_pkg;
   import tcw_pkg::*;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [CELL_W-1:0] cell_data;
      logic              scrolled;
   } cursor_report_type;

   class screen_mirror;
      logic [CELL_W-1:0]  cells [CELL_COUNT];
      int unsigned        row;
      int unsigned        col;
      logic [COLOR_W-1:0] color;
      cursor_report_type  owed_reports [$];
      int unsigned        errors;

      function new();
         color = COLOR_RESET;
         row = 0;
         col = 0;
         errors = 0;
         foreach (cells[i]) cells[i] = RESET_BLANK;
      endfunction

      function logic [CELL_W-1:0] blank();
         return {color, BLANK_CODE};
      endfunction

      function void set_color(logic [COLOR_W-1:0] value);
         color = value;
      endfunction

      function int cursor();
         return row * COLUMNS + col;
      endfunction

      function int pending();
         return owed_reports.size();
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("[%0t] %s", $time, what);
      endfunction

      // every row moves up one, bottom row blanked, cursor parks on last row
      function void scroll_screen();
         for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
         for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) cells[i] = blank();
         row = ROWS - 1;
      endfunction

      function void apply_item(op_type op, logic [CODE_W-1:0] code,
                               logic [ADDR_IN_W-1:0] addr);
         cursor_report_type r;
         r = '0;
         case (op)
            OP_PUT: begin
               if (code == NEWLINE_CODE) begin
                  row++;
                  col = 0;
               end else begin
                  cells[row * COLUMNS + col] = {color, code};
                  col++;
                  if (col >= COLUMNS) begin
                     col = 0;
                     row++;
                  end
               end
               if (row >= ROWS) begin
                  scroll_screen();
                  r.scrolled = 1'b1;
               end
            end
            OP_BACK: begin
               if (col > 0) begin
                  col--;
                  cells[row * COLUMNS + col] = blank();
               end else if (row > 0) begin
                  row--;
                  col = COLUMNS - 1;
                  cells[row * COLUMNS + col] = blank();
               end
            end
            OP_READ: begin
               if (addr < CELL_COUNT) r.cell_data = cells[addr];
            end
            default: begin
               foreach (cells[i]) cells[i] = blank();
               row = 0;
               col = 0;
            end
         endcase
         r.cursor_position = POS_W'(row * COLUMNS + col);
         owed_reports.push_back(r);
      endfunction

      function void compare_report(cursor_report_type got);
         cursor_report_type want;
         if (owed_reports.size() == 0) begin
            flag($sformatf("result with no item outstanding: pos %0d data %04h scrolled %0b",
                           got.cursor_position, got.cell_data, got.scrolled));
            return;
         end
         want = owed_reports.pop_front();
         if (want.cursor_position != got.cursor_position || want.cell_data != got.cell_data ||
             want.scrolled != got.scrolled)
            flag($sformatf("mismatch: pos %0d/%0d data %04h/%04h scrolled %0b/%0b (exp/got)",
                           want.cursor_position, got.cursor_position, want.cell_data,
                           got.cell_data, want.scrolled, got.scrolled));
      endfunction

      function void compare_color(logic [COLOR_W-1:0] got);
         if (got != color)
            flag($sformatf("text_color readback: exp %02h got %02h", color, got));
      endfunction

      function void close();
         if (owed_reports.size() != 0)
            flag($sformatf("%0d results never arrived", owed_reports.size()));
         errors += (owed_reports.size() > 1) ? owed_reports.size() - 1 : 0;
      endfunction
   endclass

endpackage

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for text_console_writer_unit: directed corner items, then phases
// of random put / backspace / read / clear traffic under different colors,
// with random gaps and result stalls, checked against a shadow screen.
// ----------------------------------------------------------------------------
module tb;
   import tcw_pkg::*;
   import screen_mirror_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD      = 10;
   localparam int QUIET_LIMIT = 12000;  // clear or scroll walks 2000 cells
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 230;
   localparam logic [CSR_ADDR_W-1:0] TEXT_COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_op = OP_PUT;
   logic [CODE_W-1:0]     req_char_code = '0;
   logic [ADDR_IN_W-1:0]  req_cell_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [POS_W-1:0]      rsp_cursor_position;
   logic [CELL_W-1:0]     rsp_cell_data;
   logic                  rsp_scrolled;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   screen_mirror board;
   bit           steady = 1'b0;   // no gaps and no stalls while set
   int unsigned  quiet_cycles = 0;

   text_console_writer_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) uut (.*);

   always #(PERIOD / 2) clock = ~clock;

   // result side stalls about one cycle in ten, never while steady is set
   always @(posedge clock)
      rsp_stall <= !steady && ($urandom_range(0, 99) < 10);

   // every accepted result is checked against the oldest outstanding one
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.compare_report({rsp_cursor_position, rsp_cell_data, rsp_scrolled});
   end

   // watchdog: a long run of cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[text_console_writer_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one item and holds it until accepted. Valid stays high on
   // exit; the next call lowers it only for a random gap, and wait_drained
   // lowers it, so it is never dropped and raised again within one step.
   task automatic send_item(op_type op, logic [CODE_W-1:0] code,
                            logic [ADDR_IN_W-1:0] addr);
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_char_code    <= code;
      req_cell_address <= addr;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.apply_item(op, code, addr);
   endtask

   // drop valid and wait until every outstanding result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; upper data bits are junk.
   // An idle phase follows so back-to-back transfers start on a new edge.
   task automatic csr_write(logic [COLOR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TEXT_COLOR_ADDR;
      csr_pwdata  <= {24'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.set_color(value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_readback();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= TEXT_COLOR_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.compare_color(csr_prdata[COLOR_W-1:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // One random item. Puts dominate so the cursor reaches the bottom and
   // scrolls; newline_pct sets how often a put is a newline (low values give
   // long lines that wrap). Half the reads land just behind the cursor.
   task automatic random_item(int newline_pct);
      int                   pick;
      int                   here;
      op_type               op;
      logic [CODE_W-1:0]    code;
      logic [ADDR_IN_W-1:0] addr;
      pick = $urandom_range(0, 999);
      code = CODE_W'($urandom);
      addr = ADDR_IN_W'($urandom);
      if (pick < 700) begin
         op = OP_PUT;
         if ($urandom_range(0, 99) < newline_pct) code = NEWLINE_CODE;
      end else if (pick < 830) begin
         op = OP_BACK;
      end else if (pick < 995) begin
         op = OP_READ;
         if ($urandom_range(0, 1) == 1) begin
            here = board.cursor();
            addr = ADDR_IN_W'((here > 90) ? here - int'($urandom_range(0, 90))
                                          : int'($urandom_range(0, here)));
         end
      end else begin
         op = OP_CLEAR;
      end
      send_item(op, code, addr);
   endtask

   initial begin
      logic [COLOR_W-1:0] hue;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset value first, then the all-ones extreme for the directed part
      csr_readback();
      csr_write(8'hFF);
      csr_readback();

      // directed: corners of the screen and of each op
      send_item(OP_BACK, 8'h41, '0);              // backspace at top-left: no-op
      send_item(OP_READ, 8'h00, 11'd0);           // reset blank
      send_item(OP_READ, 8'hFF, 11'd1999);        // last cell
      send_item(OP_READ, 8'h00, 11'd2000);        // first address past the screen
      send_item(OP_READ, 8'h00, 11'h7FF);         // top of the address field
      send_item(OP_PUT, 8'h41, 11'h7FF);
      send_item(OP_PUT, 8'h00, '0);
      send_item(OP_PUT, 8'hFF, '0);
      send_item(OP_BACK, 8'h00, '0);              // blanks cell 2
      send_item(OP_PUT, NEWLINE_CODE, '0);        // row 1, column 0
      send_item(OP_BACK, 8'h00, '0);              // back across the row boundary
      send_item(OP_READ, 8'h00, 11'd79);
      send_item(OP_READ, 8'h00, 11'd2);
      send_item(OP_READ, 8'h00, 11'd0);
      send_item(OP_PUT, 8'h7E, '0);               // lands in the last column
      send_item(OP_READ, 8'h00, 11'd79);
      send_item(OP_CLEAR, 8'h00, '0);
      send_item(OP_READ, 8'h00, 11'd5);
      send_item(OP_READ, 8'h00, 11'd79);
      send_item(OP_PUT, 8'h55, 11'h2AA);
      send_item(OP_READ, 8'hAA, 11'd0);

      // random phases, each under its own color; phase 2 runs without gaps
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         hue = (p == 0) ? 8'h00 : (p == 3) ? 8'hF0 : COLOR_W'($urandom);
         csr_write(hue);
         csr_readback();
         steady = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_item((p == 1 || p == 3) ? 2 : 30);
      end
      steady = 1'b0;

      wait_drained();
      repeat (16) @(posedge clock);
      board.close();
      if (board.errors == 0) begin
         $display("[text_console_writer_unit] OK");
      end else begin
         $display("[text_console_writer_unit] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_cursor.sv
rtl/text_console_writer_unit.sv
verif/screen_mirror_pkg.sv
verif/tb.sv
